// File: sv/ffba_pkg.sv
// Shared constants, codes and types of the first-fit bitmap allocator.
// No dependencies; compile first.
package ffba_pkg;

    localparam int MAX_BLOCKS = 64;
    localparam int IDX_W      = $clog2(MAX_BLOCKS);
    localparam int CNT_W      = IDX_W + 1;
    localparam int ST_W       = 2;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_NOSPACE = 2'd1;
    localparam logic [ST_W-1:0] ST_BADADDR = 2'd2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SEARCH = 4'b0010,
        S_WRITE  = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    // scan unit verdict, one cycle at a time
    typedef struct packed {
        logic             hit;       // run of the requested length found
        logic             fail;      // last managed entry seen, no run
        logic [IDX_W-1:0] run_start; // start of the run when hit
        logic [CNT_W-1:0] used;      // used blocks seen, valid with fail
    } t_scan_res;

endpackage

// File: sv/ffba_req_if.sv
// Request channel of the allocator: valid/ready plus request fields.
// Depends on ffba_pkg.
interface ffba_req_if;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [ffba_pkg::CNT_W-1:0] block_count;
    logic [ffba_pkg::IDX_W-1:0] start_index;

    modport source (output valid, op, block_count, start_index, input ready);
    modport sink   (input valid, op, block_count, start_index, output ready);
endinterface

// File: sv/ffba_rsp_if.sv
// Response channel of the allocator: valid/ready plus result fields.
// Depends on ffba_pkg.
interface ffba_rsp_if;
    logic                       valid;
    logic                       ready;
    logic [ffba_pkg::ST_W-1:0]  status;
    logic [ffba_pkg::IDX_W-1:0] granted_index;
    logic                       compacted;

    modport source (output valid, status, granted_index, compacted, input ready);
    modport sink   (input valid, status, granted_index, compacted, output ready);
endinterface

// File: sv/ffba_map_ram.sv
// One-bit allocation map: one write and one registered read per cycle.
// Per-entry valid flags make unwritten entries read as free. Uses ffba_pkg.
module ffba_map_ram (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_wr_en,
    input  logic [ffba_pkg::IDX_W-1:0] i_wr_addr,
    input  logic                       i_wr_data,
    input  logic                       i_rd_en,
    input  logic [ffba_pkg::IDX_W-1:0] i_rd_addr,
    output logic                       o_rd_vld,
    output logic                       o_rd_data
);

    logic                            r_mem [ffba_pkg::MAX_BLOCKS];
    logic [ffba_pkg::MAX_BLOCKS-1:0] r_valid;
    logic                            r_rd_vld;
    logic                            r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_rd_en;
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_valid[i_rd_addr] & r_mem[i_rd_addr];
    end

    assign o_rd_vld  = r_rd_vld;
    assign o_rd_data = r_rd_data;

endmodule

// File: sv/ffba_scan.sv
// Run finder: takes map bits in index order, tracks the current free run
// and counts used blocks. Uses ffba_pkg.
module ffba_scan (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clr,
    input  logic [ffba_pkg::CNT_W-1:0] i_len,
    input  logic [ffba_pkg::CNT_W-1:0] i_n,
    input  logic                       i_bit_vld,
    input  logic                       i_bit,
    output ffba_pkg::t_scan_res        o_res
);

    logic [ffba_pkg::CNT_W-1:0] r_run,   n_run;
    logic [ffba_pkg::IDX_W-1:0] r_start, n_start;
    logic [ffba_pkg::CNT_W-1:0] r_used,  n_used;
    logic [ffba_pkg::IDX_W-1:0] r_pos;
    logic                       w_last;
    logic                       w_hit;

    always_comb begin
        n_run   = r_run;
        n_start = r_start;
        n_used  = r_used;
        if (!i_bit) begin
            n_run = r_run + ffba_pkg::CNT_W'(1);
            if (r_run == '0) begin
                n_start = r_pos;
            end
        end else begin
            n_run  = '0;
            n_used = r_used + ffba_pkg::CNT_W'(1);
        end
    end

    assign w_last = ({1'b0, r_pos} == (i_n - ffba_pkg::CNT_W'(1)));
    assign w_hit  = i_bit_vld && !i_bit && (i_len != '0) && (n_run == i_len);

    assign o_res.hit       = w_hit;
    assign o_res.fail      = i_bit_vld && w_last && !w_hit;
    assign o_res.run_start = n_start;
    assign o_res.used      = n_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= '0;
            r_start <= '0;
            r_used  <= '0;
            r_pos   <= '0;
        end else if (i_clr) begin
            r_run   <= '0;
            r_start <= '0;
            r_used  <= '0;
            r_pos   <= '0;
        end else if (i_bit_vld) begin
            r_run   <= n_run;
            r_start <= n_start;
            r_used  <= n_used;
            r_pos   <= r_pos + ffba_pkg::IDX_W'(1);
        end
    end

endmodule

// File: sv/first_fit_bitmap_allocator_top.sv
// First-fit bitmap allocator with compaction; one response item per request item.
// Allocate: a search pass reads the map up to the end of the first fitting run, then
// a sweep marks the run used; a failed search instead runs a compaction sweep over
// all n entries. Free sweeps its clipped range; a bad address skips the sweep.
// One request at a time; the next is accepted in the cycle after the response loads.
// Synchronous active-low reset empties the map at once (valid flags), sets 64 blocks.
module first_fit_bitmap_allocator_top (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [ffba_pkg::CNT_W-1:0] i_cfg_wdata,
    ffba_req_if.sink                   i_req,
    ffba_rsp_if.source                 o_rsp
);

    // configuration, clamped to 1..MAX_BLOCKS
    logic [ffba_pkg::CNT_W-1:0] r_managed_blocks;
    logic [ffba_pkg::CNT_W-1:0] w_n;

    // sequencer
    ffba_pkg::t_state r_state, n_state;

    // latched request
    logic                       r_op;
    logic [ffba_pkg::CNT_W-1:0] r_cnt;

    // read pointer for the search pass
    logic [ffba_pkg::CNT_W-1:0] r_rd_addr;
    logic                       w_rd_en;

    // write sweep: entries ptr..stop-1 get (ptr < thresh)
    logic [ffba_pkg::CNT_W-1:0] r_wr_ptr, r_wr_stop, r_wr_thresh;
    logic                       w_wr_en;

    // result being built, and the output register
    logic [ffba_pkg::ST_W-1:0]  r_status;
    logic [ffba_pkg::IDX_W-1:0] r_granted;
    logic                       r_comp;
    logic                       r_rsp_vld;
    logic [ffba_pkg::ST_W-1:0]  r_rsp_status;
    logic [ffba_pkg::IDX_W-1:0] r_rsp_granted;
    logic                       r_rsp_comp;

    logic                       w_accept;
    logic                       w_load_rsp;
    logic                       w_ram_vld, w_ram_bit;
    ffba_pkg::t_scan_res        w_scan;

    // compaction retry: packed map leaves one free run from 'used' to n-1
    logic [ffba_pkg::CNT_W-1:0] w_free_left;
    logic                       w_retry_ok;
    // start + count needs one bit more than the count
    logic [ffba_pkg::CNT_W:0]   w_free_sum;
    logic [ffba_pkg::CNT_W-1:0] w_free_stop;

    always_comb begin
        w_n = r_managed_blocks;
        if (r_managed_blocks == '0) begin
            w_n = ffba_pkg::CNT_W'(1);
        end else if (r_managed_blocks > ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS)) begin
            w_n = ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS);
        end
    end

    assign w_accept    = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == ffba_pkg::S_IDLE);
    assign w_load_rsp  = (r_state == ffba_pkg::S_DONE) && (!r_rsp_vld || o_rsp.ready);

    assign w_rd_en = (r_state == ffba_pkg::S_SEARCH) && (r_rd_addr < w_n);
    assign w_wr_en = (r_state == ffba_pkg::S_WRITE) && (r_wr_ptr < r_wr_stop);

    assign w_free_left = w_n - w_scan.used;
    assign w_retry_ok  = (r_cnt != '0) && (r_cnt <= w_free_left);

    assign w_free_sum  = {2'b0, i_req.start_index} + {1'b0, i_req.block_count};
    assign w_free_stop = (w_free_sum > {1'b0, w_n}) ? w_n
                                                    : w_free_sum[ffba_pkg::CNT_W-1:0];

    ffba_map_ram u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_wr_ptr[ffba_pkg::IDX_W-1:0]),
        .i_wr_data (r_wr_ptr < r_wr_thresh),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (r_rd_addr[ffba_pkg::IDX_W-1:0]),
        .o_rd_vld  (w_ram_vld),
        .o_rd_data (w_ram_bit)
    );

    // only bits read during the search feed the finder; late reads are dropped
    ffba_scan u_scan (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clr     (w_accept),
        .i_len     (r_cnt),
        .i_n       (w_n),
        .i_bit_vld (w_ram_vld && (r_state == ffba_pkg::S_SEARCH)),
        .i_bit     (w_ram_bit),
        .o_res     (w_scan)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            ffba_pkg::S_IDLE: begin
                if (w_accept) begin
                    if (i_req.op == ffba_pkg::OP_ALLOC) begin
                        n_state = ffba_pkg::S_SEARCH;
                    end else if ({1'b0, i_req.start_index} >= w_n) begin
                        n_state = ffba_pkg::S_DONE;
                    end else begin
                        n_state = ffba_pkg::S_WRITE;
                    end
                end
            end
            ffba_pkg::S_SEARCH: begin
                if (w_scan.hit || w_scan.fail) begin
                    n_state = ffba_pkg::S_WRITE;
                end
            end
            ffba_pkg::S_WRITE: begin
                if (!w_wr_en) begin
                    n_state = ffba_pkg::S_DONE;
                end
            end
            ffba_pkg::S_DONE: begin
                if (w_load_rsp) begin
                    n_state = ffba_pkg::S_IDLE;
                end
            end
            default: n_state = ffba_pkg::S_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state          <= ffba_pkg::S_IDLE;
            r_managed_blocks <= ffba_pkg::CNT_W'(ffba_pkg::MAX_BLOCKS);
            r_rsp_vld        <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_managed_blocks <= i_cfg_wdata;
            end
            if (w_load_rsp) begin
                r_rsp_vld <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_vld <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op        <= i_req.op;
            r_cnt       <= i_req.block_count;
            r_rd_addr   <= '0;
            r_status    <= ffba_pkg::ST_OK;
            r_granted   <= '0;
            r_comp      <= 1'b0;
            // free: clear start..min(start+count, n)-1
            r_wr_ptr    <= {1'b0, i_req.start_index};
            r_wr_stop   <= w_free_stop;
            r_wr_thresh <= '0;
            if (i_req.op == ffba_pkg::OP_FREE && {1'b0, i_req.start_index} >= w_n) begin
                r_status <= ffba_pkg::ST_BADADDR;
            end
        end else if (r_state == ffba_pkg::S_SEARCH) begin
            if (w_rd_en) begin
                r_rd_addr <= r_rd_addr + ffba_pkg::CNT_W'(1);
            end
            if (w_scan.hit) begin
                // mark the found run used
                r_granted   <= w_scan.run_start;
                r_wr_ptr    <= {1'b0, w_scan.run_start};
                r_wr_stop   <= {1'b0, w_scan.run_start} + r_cnt;
                r_wr_thresh <= {1'b0, w_scan.run_start} + r_cnt;
            end else if (w_scan.fail) begin
                // compaction sweep over the whole range, folding in the retry grant
                r_comp    <= 1'b1;
                r_wr_ptr  <= '0;
                r_wr_stop <= w_n;
                if (w_retry_ok) begin
                    r_granted   <= w_scan.used[ffba_pkg::IDX_W-1:0];
                    r_wr_thresh <= w_scan.used + r_cnt;
                end else begin
                    r_status    <= ffba_pkg::ST_NOSPACE;
                    r_wr_thresh <= w_scan.used;
                end
            end
        end else if (w_wr_en) begin
            r_wr_ptr <= r_wr_ptr + ffba_pkg::CNT_W'(1);
        end
        if (w_load_rsp) begin
            r_rsp_status  <= r_status;
            r_rsp_granted <= r_granted;
            r_rsp_comp    <= r_comp;
        end
    end

    assign o_rsp.valid         = r_rsp_vld;
    assign o_rsp.status        = r_rsp_status;
    assign o_rsp.granted_index = r_rsp_granted;
    assign o_rsp.compacted     = r_rsp_comp;

    // a taken request always leaves idle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state != ffba_pkg::S_IDLE))
        else $error("request taken but sequencer stayed idle");

    // no sweep runs past the managed range
    a_sweep_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffba_pkg::S_WRITE) |-> (r_wr_stop <= w_n))
        else $error("write sweep beyond managed blocks");

    // a bad free address never carries a grant or a compaction
    a_badaddr_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rsp_vld |-> ((r_rsp_status != ffba_pkg::ST_BADADDR)
                       || (!r_rsp_comp && r_rsp_granted == '0)))
        else $error("bad-address response with grant or compaction");

    // frees never compact
    a_free_no_compact: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ffba_pkg::S_DONE && r_op == ffba_pkg::OP_FREE) |-> !r_comp)
        else $error("free request flagged as compacting");

endmodule
